[rtl/core/lsu_pkg.sv]
// Shared types and constants for the link setup (SET/UA) initiator.
// No dependencies; compiled first.
`default_nettype none

package lsu_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Link phase, also reported as link_status
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_CONN = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    // Reply frame matcher
    typedef enum logic [2:0] {
        M_START = 3'd0,
        M_FLAG  = 3'd1,
        M_ADDR  = 3'd2,
        M_CTRL  = 3'd3,
        M_BCC   = 3'd4,
        M_DONE  = 3'd5
    } match_t;

    // Configuration register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_TIMEOUT_TICKS   = 3'd0,
        REG_MAX_TIMEOUTS    = 3'd1,
        REG_FLAG_BYTE       = 3'd2,
        REG_COMMAND_ADDRESS = 3'd3,
        REG_REPLY_ADDRESS   = 3'd4,
        REG_CONTROL_CODE    = 3'd5
    } reg_idx_t;

    localparam int unsigned PADDR_W = 5;

    // Frame beats: flag, address, control, check, flag
    localparam logic [2:0] BEAT_FIRST = 3'd0;
    localparam logic [2:0] BEAT_ADDR  = 3'd1;
    localparam logic [2:0] BEAT_CTRL  = 3'd2;
    localparam logic [2:0] BEAT_BCC   = 3'd3;
    localparam logic [2:0] BEAT_LAST  = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_TIMEOUT_TICKS   = 32'd3;
    localparam logic [3:0]  RST_MAX_TIMEOUTS    = 4'd3;
    localparam logic [7:0]  RST_FLAG_BYTE       = 8'h7e;
    localparam logic [7:0]  RST_COMMAND_ADDRESS = 8'h03;
    localparam logic [7:0]  RST_REPLY_ADDRESS   = 8'h01;
    localparam logic [7:0]  RST_CONTROL_CODE    = 8'h03;

endpackage

`default_nettype wire

[rtl/core/lsu_in_if.sv]
// Input channel of the link setup initiator: action and received byte.
// Standalone interface, valid/ready handshake.
`default_nettype none

interface lsu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/lsu_out_if.sv]
// Result channel of the link setup initiator: frame byte and link status.
// Standalone interface, valid/ready handshake.
`default_nettype none

interface lsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       frame_last;
    logic [1:0] link_status;

    modport source (output valid, output tx_byte, output tx_valid, output frame_last,
                    output link_status, input ready);
    modport sink   (input valid, input tx_byte, input tx_valid, input frame_last,
                    input link_status, output ready);
endinterface

`default_nettype wire

[rtl/core/link_setup_set_ua_retry.sv]
// Link setup initiator: sends the SET frame, matches the UA reply, retries on timeout.
// An accepted transfer waits in the input register until the result stage is free;
// its first result is then registered and offered. Throughput, while ready is high:
// one item per cycle for status results; a start or resend holds the result stage for
// its whole frame, one frame byte per cycle, and no new item is processed meanwhile.
// Reset (rst_n, async, active low): idle phase, empty stages, registers at defaults.
`default_nettype none

module link_setup_set_ua_retry (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lsu_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    lsu_in_if.sink                          item_in,
    lsu_out_if.source                       result_out
);
    import lsu_pkg::*;

    // Configuration registers
    logic [31:0] timeout_ticks_reg;
    logic [3:0]  max_timeouts_reg;
    logic [7:0]  flag_byte_reg;
    logic [7:0]  command_address_reg;
    logic [7:0]  reply_address_reg;
    logic [7:0]  control_code_reg;

    // Input register
    logic        in_valid_reg;
    action_t     in_action_reg;
    logic [7:0]  in_byte_reg;

    // Link state
    match_t      match_reg, match_next, match_adv;
    logic [31:0] tick_reg, tick_next, tick_inc;
    logic [3:0]  tocnt_reg, tocnt_next, tocnt_inc;
    phase_t      phase_reg, phase_next;
    logic        emit_frame;

    // Result register
    logic        out_valid_reg;
    logic        out_frame_reg;
    logic [2:0]  beat_reg;
    phase_t      status_reg;

    logic        cfg_write;
    reg_idx_t    cfg_idx;
    logic        out_last;
    logic        out_take;
    logic        out_free;
    logic        load;
    logic [7:0]  reply_bcc;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg   <= RST_TIMEOUT_TICKS;
            max_timeouts_reg    <= RST_MAX_TIMEOUTS;
            flag_byte_reg       <= RST_FLAG_BYTE;
            command_address_reg <= RST_COMMAND_ADDRESS;
            reply_address_reg   <= RST_REPLY_ADDRESS;
            control_code_reg    <= RST_CONTROL_CODE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_TIMEOUT_TICKS:   timeout_ticks_reg   <= pwdata;
                REG_MAX_TIMEOUTS:    max_timeouts_reg    <= pwdata[3:0];
                REG_FLAG_BYTE:       flag_byte_reg       <= pwdata[7:0];
                REG_COMMAND_ADDRESS: command_address_reg <= pwdata[7:0];
                REG_REPLY_ADDRESS:   reply_address_reg   <= pwdata[7:0];
                REG_CONTROL_CODE:    control_code_reg    <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_TIMEOUT_TICKS:   prdata = timeout_ticks_reg;
            REG_MAX_TIMEOUTS:    prdata = {28'd0, max_timeouts_reg};
            REG_FLAG_BYTE:       prdata = {24'd0, flag_byte_reg};
            REG_COMMAND_ADDRESS: prdata = {24'd0, command_address_reg};
            REG_REPLY_ADDRESS:   prdata = {24'd0, reply_address_reg};
            REG_CONTROL_CODE:    prdata = {24'd0, control_code_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Handshake between the input register and the result register
    assign out_last = !out_frame_reg || (beat_reg == BEAT_LAST);
    assign out_take = out_valid_reg && result_out.ready;
    assign out_free = !out_valid_reg || (result_out.ready && out_last);
    assign load     = in_valid_reg && out_free;
    assign item_in.ready = !in_valid_reg || load;

    // Capture the incoming transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            in_action_reg <= action_t'(item_in.action);
            in_byte_reg   <= item_in.rx_byte;
        end
    end

    // Reply matcher step; a wrong byte falls back to flag-seen or start
    assign reply_bcc = reply_address_reg ^ control_code_reg;

    always_comb
    begin
        match_adv = (in_byte_reg == flag_byte_reg) ? M_FLAG : M_START;
        unique case (match_reg)
            M_START: ;
            M_FLAG:  if (in_byte_reg == reply_address_reg) match_adv = M_ADDR;
            M_ADDR:  if (in_byte_reg == control_code_reg)  match_adv = M_CTRL;
            M_CTRL:  if (in_byte_reg == reply_bcc)         match_adv = M_BCC;
            M_BCC:   match_adv = (in_byte_reg == flag_byte_reg) ? M_DONE : M_START;
            default: match_adv = match_reg;
        endcase
    end

    // Next link state for the item in the input register
    assign tick_inc  = tick_reg + 32'd1;
    assign tocnt_inc = tocnt_reg + 4'd1;

    always_comb
    begin
        match_next = match_reg;
        tick_next  = tick_reg;
        tocnt_next = tocnt_reg;
        phase_next = phase_reg;
        emit_frame = 1'b0;
        case (in_action_reg)
            ACT_START:
            begin
                match_next = M_START;
                tick_next  = 32'd0;
                tocnt_next = 4'd0;
                phase_next = PH_WAIT;
                emit_frame = 1'b1;
            end
            ACT_BYTE:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    match_next = match_adv;
                    if (match_adv == M_DONE)
                    begin
                        phase_next = PH_CONN;
                    end
                end
            end
            ACT_TICK:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= timeout_ticks_reg)
                    begin
                        tick_next  = 32'd0;
                        tocnt_next = tocnt_inc;
                        if (tocnt_inc >= max_timeouts_reg)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            emit_frame = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Commit state and load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= M_START;
            tick_reg      <= 32'd0;
            tocnt_reg     <= 4'd0;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            out_frame_reg <= 1'b0;
            beat_reg      <= BEAT_FIRST;
            status_reg    <= PH_IDLE;
        end
        else if (load)
        begin
            match_reg     <= match_next;
            tick_reg      <= tick_next;
            tocnt_reg     <= tocnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= 1'b1;
            out_frame_reg <= emit_frame;
            beat_reg      <= BEAT_FIRST;
            status_reg    <= phase_next;
        end
        else if (out_take)
        begin
            // advance through the frame, drop the stage after the last beat
            if (out_last)
            begin
                out_valid_reg <= 1'b0;
                out_frame_reg <= 1'b0;
                beat_reg      <= BEAT_FIRST;
            end
            else
            begin
                beat_reg <= beat_reg + 3'd1;
            end
        end
    end

    // Result payload
    always_comb
    begin
        result_out.tx_byte = 8'd0;
        if (out_frame_reg)
        begin
            unique case (beat_reg)
                BEAT_ADDR: result_out.tx_byte = command_address_reg;
                BEAT_CTRL: result_out.tx_byte = control_code_reg;
                BEAT_BCC:  result_out.tx_byte = command_address_reg ^ control_code_reg;
                default:   result_out.tx_byte = flag_byte_reg;
            endcase
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.tx_valid    = out_frame_reg;
    assign result_out.frame_last  = out_last;
    assign result_out.link_status = status_reg;

`ifndef SYNTHESIS
    // A beat past the first only exists inside a frame being sent
    a_beat_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != BEAT_FIRST) |-> (out_valid_reg && out_frame_reg))
        else $error("frame beat counter running outside a frame");

    // A processed start leaves the link waiting with a fresh frame at its first beat
    a_start_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (load && in_action_reg == ACT_START) |=>
            (phase_reg == PH_WAIT && match_reg == M_START && out_frame_reg
             && beat_reg == BEAT_FIRST && status_reg == PH_WAIT))
        else $error("start did not restart the link");

    // The last result taken with nothing behind it empties the result stage
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && out_last && !in_valid_reg) |=> !out_valid_reg)
        else $error("result stage kept a delivered result");

    // No new item enters the result stage in the middle of a frame
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_frame_reg && beat_reg != BEAT_LAST) |-> !load)
        else $error("item processed while a frame is still being sent");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for link_setup_set_ua_retry: SET frame emission, UA reply
// matching, tick timeouts, resends and failure. Uses lsu_pkg, lsu_in_if, lsu_out_if.
// Predicts every result in-line and compares each result transfer in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 200;
    localparam int PHASES      = 8;

    typedef struct packed {
        action_t    act;
        logic [7:0] data;
    } link_event_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       frame_last;
        phase_t     link_status;
    } link_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    lsu_in_if  in_ch ();
    lsu_out_if out_ch ();

    link_setup_set_ua_retry DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_in    (in_ch),
        .result_out (out_ch)
    );

    // Register shadow copy
    logic [31:0] cfg_timeout_ticks = RST_TIMEOUT_TICKS;
    logic [3:0]  cfg_max_timeouts  = RST_MAX_TIMEOUTS;
    logic [7:0]  cfg_flag          = RST_FLAG_BYTE;
    logic [7:0]  cfg_cmd_addr      = RST_COMMAND_ADDRESS;
    logic [7:0]  cfg_reply_addr    = RST_REPLY_ADDRESS;
    logic [7:0]  cfg_ctrl          = RST_CONTROL_CODE;

    // Predicted link state
    match_t      match_st    = M_START;
    logic [31:0] tick_cnt    = '0;
    logic [3:0]  timeout_cnt = '0;
    phase_t      link_phase  = PH_IDLE;

    link_event_t  link_events_q [$];
    link_result_t tx_status_q [$];
    link_event_t  offer_item;

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  in_taken       = 0;
    bit  hold_recv      = 0;
    bit  stall_req      = 0;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_result(logic [7:0] tx_b, logic tx_v, logic last);
        link_result_t r;
        r.tx_byte     = tx_b;
        r.tx_valid    = tx_v;
        r.frame_last  = last;
        r.link_status = link_phase;
        tx_status_q.push_back(r);
    endfunction

    function automatic void push_set_frame();
        logic [7:0] fr [5];
        fr = '{cfg_flag, cfg_cmd_addr, cfg_ctrl, cfg_cmd_addr ^ cfg_ctrl, cfg_flag};
        for (int k = 0; k < 5; k++)
            push_result(fr[k], 1'b1, k == 4);
    endfunction

    // Advance the link state by one accepted transfer and queue its results
    function automatic void predict_link_step(action_t act, logic [7:0] rx);
        logic [7:0] bcc;
        bcc = cfg_reply_addr ^ cfg_ctrl;
        case (act)
            ACT_START:
            begin
                match_st    = M_START;
                tick_cnt    = '0;
                timeout_cnt = '0;
                link_phase  = PH_WAIT;
                push_set_frame();
                return;
            end
            ACT_BYTE:
                if (link_phase == PH_WAIT)
                begin
                    case (match_st)
                        M_START: match_st = (rx == cfg_flag) ? M_FLAG : M_START;
                        M_FLAG:  match_st = (rx == cfg_reply_addr) ? M_ADDR :
                                            (rx == cfg_flag) ? M_FLAG : M_START;
                        M_ADDR:  match_st = (rx == cfg_ctrl) ? M_CTRL :
                                            (rx == cfg_flag) ? M_FLAG : M_START;
                        M_CTRL:  match_st = (rx == bcc) ? M_BCC :
                                            (rx == cfg_flag) ? M_FLAG : M_START;
                        M_BCC:   match_st = (rx == cfg_flag) ? M_DONE : M_START;
                        default: ;
                    endcase
                    if (match_st == M_DONE)
                        link_phase = PH_CONN;
                end
            ACT_TICK:
                if (link_phase == PH_WAIT)
                begin
                    tick_cnt = tick_cnt + 32'd1;
                    if (tick_cnt >= cfg_timeout_ticks)
                    begin
                        tick_cnt    = '0;
                        timeout_cnt = timeout_cnt + 4'd1;
                        if (timeout_cnt >= cfg_max_timeouts)
                            link_phase = PH_FAIL;
                        else
                        begin
                            push_set_frame();
                            return;
                        end
                    end
                end
            default: ;
        endcase
        push_result(8'h00, 1'b0, 1'b1);
    endfunction

    // Drive the input channel and the result ready at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (!in_ch.valid || in_taken)
            begin
                in_taken = 0;
                if (link_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offer_item = link_events_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.action  <= offer_item.act;
                    in_ch.rx_byte <= offer_item.data;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sample transfers at the rising edge: predict inputs, check results
    always @(posedge clk)
    begin
        link_result_t seen;
        link_result_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_link_step(action_t'(in_ch.action), in_ch.rx_byte);
            items_accepted++;
            in_taken = 1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.tx_byte     = out_ch.tx_byte;
            seen.tx_valid    = out_ch.tx_valid;
            seen.frame_last  = out_ch.frame_last;
            seen.link_status = phase_t'(out_ch.link_status);
            if (tx_status_q.size() == 0)
            begin
                $error("unexpected result transfer: tx_byte %0h", seen.tx_byte);
                mismatch_count++;
            end
            else
            begin
                want = tx_status_q.pop_front();
                if (seen.tx_byte !== want.tx_byte)
                begin
                    $error("tx_byte: expected %0h, got %0h", want.tx_byte, seen.tx_byte);
                    mismatch_count++;
                end
                if (seen.tx_valid !== want.tx_valid)
                begin
                    $error("tx_valid: expected %0b, got %0b", want.tx_valid, seen.tx_valid);
                    mismatch_count++;
                end
                if (seen.frame_last !== want.frame_last)
                begin
                    $error("frame_last: expected %0b, got %0b",
                           want.frame_last, seen.frame_last);
                    mismatch_count++;
                end
                if (seen.link_status !== want.link_status)
                begin
                    $error("link_status: expected %0d, got %0d",
                           want.link_status, seen.link_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        wait (stall_req);
        hold_recv = 1;
        repeat (LONG_STALL) @(posedge clk);
        hold_recv = 0;
    end

    task automatic add_event(action_t act, logic [7:0] data);
        link_event_t e;
        e.act  = act;
        e.data = data;
        link_events_q.push_back(e);
        items_queued++;
    endtask

    task automatic add_noise();
        add_event(action_t'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    // Queue a UA reply; optionally corrupt one byte
    task automatic add_reply(bit broken);
        logic [7:0] fr [5];
        fr = '{cfg_flag, cfg_reply_addr, cfg_ctrl, cfg_reply_addr ^ cfg_ctrl, cfg_flag};
        if (broken)
            fr[$urandom_range(4)] = 8'($urandom_range(255));
        for (int k = 0; k < 5; k++)
            add_event(ACT_BYTE, fr[k]);
    endtask

    // Write a register, read it back, and update the shadow copy
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        logic [31:0] readback;
        case (idx)
            REG_TIMEOUT_TICKS:   cfg_timeout_ticks = val;
            REG_MAX_TIMEOUTS:    cfg_max_timeouts  = val[3:0];
            REG_FLAG_BYTE:       cfg_flag          = val[7:0];
            REG_COMMAND_ADDRESS: cfg_cmd_addr      = val[7:0];
            REG_REPLY_ADDRESS:   cfg_reply_addr    = val[7:0];
            default:             cfg_ctrl          = val[7:0];
        endcase
        readback = (idx == REG_TIMEOUT_TICKS) ? val :
                   (idx == REG_MAX_TIMEOUTS) ? {28'd0, val[3:0]} : {24'd0, val[7:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== readback)
        begin
            $error("prdata: expected %0h, got %0h", readback, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] t_ticks, logic [3:0] max_t, logic [7:0] flag,
                             logic [7:0] cmd_a, logic [7:0] rep_a, logic [7:0] ctrl);
        write_reg(REG_TIMEOUT_TICKS, t_ticks);
        write_reg(REG_MAX_TIMEOUTS, {28'd0, max_t});
        write_reg(REG_FLAG_BYTE, {24'd0, flag});
        write_reg(REG_COMMAND_ADDRESS, {24'd0, cmd_a});
        write_reg(REG_REPLY_ADDRESS, {24'd0, rep_a});
        write_reg(REG_CONTROL_CODE, {24'd0, ctrl});
    endtask

    // Hold the sender until every queued transfer is accepted and answered
    task automatic wait_drained();
        while (items_accepted != items_queued || tx_status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    // Mostly setup exchanges with random content, some timeouts, some noise
    task automatic gen_traffic(int count);
        int base;
        int pick;
        int per;
        int n_ticks;
        base = items_queued;
        while (items_queued - base < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                add_event(ACT_START, 8'($urandom_range(255)));
                repeat ($urandom_range(2)) add_event(ACT_BYTE, 8'($urandom_range(255)));
                repeat ($urandom_range(2)) add_event(ACT_TICK, 8'($urandom_range(255)));
                if ($urandom_range(3) == 0)
                    add_event(ACT_BYTE, cfg_flag);
                add_reply($urandom_range(99) < 25);
                repeat ($urandom_range(2)) add_noise();
            end
            else if (pick < 75)
            begin
                per = (cfg_timeout_ticks == 0) ? 1 :
                      (cfg_timeout_ticks > 6) ? 6 : int'(cfg_timeout_ticks);
                n_ticks = per * (int'(cfg_max_timeouts) + 1) - $urandom_range(1);
                if (n_ticks > 40)
                    n_ticks = 40;
                add_event(ACT_START, 8'($urandom_range(255)));
                repeat (n_ticks)
                begin
                    if ($urandom_range(4) == 0)
                        add_event(ACT_BYTE, 8'($urandom_range(255)));
                    add_event(ACT_TICK, 8'($urandom_range(255)));
                end
            end
            else
                repeat ($urandom_range(1, 4)) add_noise();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.action  = ACT_NONE;
        in_ch.rx_byte = 8'h00;
        out_ch.ready  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pass at reset defaults, no idling
        set_idling(0);
        add_event(ACT_TICK, 8'h00);      // tick while idle
        add_event(ACT_BYTE, 8'hff);      // byte while idle
        add_event(ACT_NONE, 8'h55);      // undefined action
        add_event(ACT_START, 8'h00);
        add_event(ACT_BYTE, 8'h00);      // noise in start state
        add_event(ACT_BYTE, RST_FLAG_BYTE);
        add_event(ACT_BYTE, RST_FLAG_BYTE);  // repeated flag keeps flag-seen
        add_event(ACT_BYTE, RST_REPLY_ADDRESS);
        add_event(ACT_BYTE, RST_FLAG_BYTE);  // flag falls back to flag-seen
        add_event(ACT_BYTE, RST_REPLY_ADDRESS);
        add_event(ACT_BYTE, RST_CONTROL_CODE);
        repeat (3) add_event(ACT_TICK, 8'h00);  // timeout, resend keeps matcher
        add_event(ACT_BYTE, RST_REPLY_ADDRESS ^ RST_CONTROL_CODE);
        add_event(ACT_BYTE, RST_FLAG_BYTE);  // reply complete, connected
        add_event(ACT_BYTE, RST_FLAG_BYTE);  // ignored once connected
        add_event(ACT_TICK, 8'hff);
        add_event(ACT_NONE, 8'haa);
        add_event(ACT_START, 8'hff);     // restart from connected
        repeat (9) add_event(ACT_TICK, 8'h00);  // two resends, then failure
        add_event(ACT_BYTE, RST_FLAG_BYTE);  // ignored once failed
        wait_drained();

        // Configuration phases, extremes first, then random settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_idling(ph % 4);
            case (ph)
                0: write_all(32'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00);
                1: write_all(32'd1, 4'd15, 8'hff, 8'hff, 8'hff, 8'hff);
                2: write_all(32'hffff_ffff, 4'd1, 8'h7e, 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
                3: write_all(32'd2, 4'd3, 8'h55, 8'haa, 8'h55, 8'h0f);
                default: write_all(32'($urandom_range(6)), 4'($urandom_range(5)),
                                   8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            if (ph == 2)
                stall_req = 1;
            gen_traffic(24);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && tx_status_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
